FILE: hdl/big_endian_typed_serializer_assert.svh
// Assertion macros for the big-endian typed serializer.
// Included by the top level; expects signals clk and rst_n in scope.
`ifndef BIG_ENDIAN_TYPED_SERIALIZER_ASSERT_SVH
`define BIG_ENDIAN_TYPED_SERIALIZER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define BETS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bets assertion failed");

// Check that a condition implies another in the next cycle.
`define BETS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bets assertion failed");

`endif

FILE: hdl/bets_pkg.sv
// Shared types and constants for the big-endian typed serializer.
// No dependencies; used by every module of the block.
package bets_pkg;

  // Operation codes
  localparam logic [2:0] OP_BYTE  = 3'd0;
  localparam logic [2:0] OP_BOOL  = 3'd1;
  localparam logic [2:0] OP_SHORT = 3'd2;
  localparam logic [2:0] OP_INT   = 3'd3;
  localparam logic [2:0] OP_LONG  = 3'd4;
  localparam logic [2:0] OP_UTF   = 3'd5;

  // Modified UTF-8 marks and masks
  localparam logic [7:0]  UTF_LEAD3   = 8'hE0;
  localparam logic [7:0]  UTF_LEAD2   = 8'hC0;
  localparam logic [7:0]  UTF_CONT    = 8'h80;
  localparam logic [15:0] UTF_MAX1    = 16'h007F;
  localparam logic [15:0] UTF_MAX2    = 16'h07FF;

  // Encoded item: bytes left aligned, most significant first
  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
  } enc_t;

  // Serializer status seen by the top level
  typedef struct packed {
    logic       take;
    logic [2:0] rem;
  } ser_stat_t;

endpackage

FILE: hdl/bets_encoder.sv
// Input register and byte encoder of the big-endian typed serializer.
// Depends on bets_pkg for operation codes and the encoded item type.
module bets_encoder
  import bets_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_value,
  output logic        enc_valid,
  input  logic        enc_take,
  output enc_t        enc
);

  logic        valid_r;
  logic [2:0]  op_r;
  logic [63:0] value_r;
  logic [15:0] unit;
  logic        known_op;

  assign in_ready  = !valid_r || enc_take;
  assign enc_valid = valid_r;
  assign known_op  = (in_operation <= OP_UTF);

  // Capture a transaction; drop unused operation codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid && known_op;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_operation;
      value_r <= in_value;
    end
  end

  assign unit = value_r[15:0];

  // Build the left-aligned byte string and its length
  always_comb begin
    enc.bytes = '0;
    enc.count = 4'd0;
    case (op_r)
      OP_BYTE: begin
        enc.bytes = {value_r[7:0], 56'd0};
        enc.count = 4'd1;
      end
      OP_BOOL: begin
        enc.bytes = {7'd0, |value_r, 56'd0};
        enc.count = 4'd1;
      end
      OP_SHORT: begin
        enc.bytes = {value_r[15:0], 48'd0};
        enc.count = 4'd2;
      end
      OP_INT: begin
        enc.bytes = {value_r[31:0], 32'd0};
        enc.count = 4'd4;
      end
      OP_LONG: begin
        enc.bytes = value_r;
        enc.count = 4'd8;
      end
      OP_UTF: begin
        if (unit != 16'd0 && unit <= UTF_MAX1) begin
          enc.bytes = {unit[7:0], 56'd0};
          enc.count = 4'd1;
        end else if (unit > UTF_MAX2) begin
          enc.bytes = {UTF_LEAD3 | {4'd0, unit[15:12]},
                       UTF_CONT | {2'd0, unit[11:6]},
                       UTF_CONT | {2'd0, unit[5:0]}, 40'd0};
          enc.count = 4'd3;
        end else begin
          enc.bytes = {UTF_LEAD2 | {3'd0, unit[10:6]},
                       UTF_CONT | {2'd0, unit[5:0]}, 48'd0};
          enc.count = 4'd2;
        end
      end
      default: begin
        enc.bytes = '0;
        enc.count = 4'd0;
      end
    endcase
  end

endmodule

FILE: hdl/bets_serializer.sv
// Output register and byte shifter of the big-endian typed serializer.
// Depends on bets_pkg for the encoded item and status types.
module bets_serializer
  import bets_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        enc_valid,
  input  enc_t        enc,
  output ser_stat_t   stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic [31:0] out_bytes_written
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic [31:0] count_r;
  logic [55:0] shift_r;
  logic [2:0]  rem_r;
  logic        advance;
  logic        more;

  assign advance   = !valid_r || out_ready;
  assign more      = valid_r && (rem_r != 3'd0);
  assign stat.take = advance && !more && enc_valid;
  assign stat.rem  = rem_r;

  // Control state: valid flag, remaining bytes and running count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rem_r   <= 3'd0;
      count_r <= 32'd0;
    end else if (advance) begin
      if (more) begin
        valid_r <= 1'b1;
        rem_r   <= rem_r - 3'd1;
        count_r <= count_r + 32'd1;
      end else if (enc_valid) begin
        valid_r <= 1'b1;
        rem_r   <= 3'(enc.count - 4'd1);
        count_r <= count_r + 32'd1;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload: next byte from the shifter or the first byte of a new item
  always_ff @(posedge clk) begin
    if (advance) begin
      if (more) begin
        byte_r  <= shift_r[55:48];
        shift_r <= {shift_r[47:0], 8'd0};
        last_r  <= (rem_r == 3'd1);
      end else if (enc_valid) begin
        byte_r  <= enc.bytes[63:56];
        shift_r <= enc.bytes[55:0];
        last_r  <= (enc.count == 4'd1);
      end
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_last_byte     = last_r;
  assign out_bytes_written = count_r;

endmodule

FILE: hdl/big_endian_typed_serializer.sv
// Top level of the big-endian typed serializer.
// Depends on bets_pkg, bets_encoder, bets_serializer and the assert macro header.
//
//  channel | ports                                      | direction
//  input   | in_valid/in_ready, in_operation, in_value  | one typed value per transaction
//  output  | out_valid/out_ready, out_byte,             | one byte per transaction
//          | out_last_byte, out_bytes_written           |
//
// An item giving n bytes (1..8) leaves the output register one byte at a time; the
// output register sends one byte per cycle unless out_ready stalls it, which sets the rate.
// An accepted input passes the encoder register, then the output register.
// Synchronous active-low reset clears the valid flags and the byte count.
// Operation codes 6 and 7 are accepted and dropped without output.
// An output stall holds the current byte; the input register fills and then stalls.
module big_endian_typed_serializer
  import bets_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_byte,
  output logic [31:0] out_bytes_written
);

  `include "big_endian_typed_serializer_assert.svh"

  logic      enc_valid;
  enc_t      enc;
  ser_stat_t stat;

  // Capture and encode
  bets_encoder u_encoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .enc_valid    (enc_valid),
    .enc_take     (stat.take),
    .enc          (enc)
  );

  // Serialize one byte per cycle while the output is not stalled
  bets_serializer u_serializer (
    .clk               (clk),
    .rst_n             (rst_n),
    .enc_valid         (enc_valid),
    .enc               (enc),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_byte     (out_last_byte),
    .out_bytes_written (out_bytes_written)
  );

  // Last flag marks exactly the byte with nothing left behind it
  `BETS_ASSERT_SAME(a_last_rem, out_valid, out_last_byte == (stat.rem == 3'd0))
  // A byte that is not last is followed directly by the next one
  `BETS_ASSERT_NEXT(a_cont, out_valid && out_ready && !out_last_byte, out_valid)
  // Each new byte advances the count by one
  `BETS_ASSERT_NEXT(a_count, out_valid && out_ready,
                    !out_valid || out_bytes_written == $past(out_bytes_written) + 32'd1)
  // The input stalls only when an encoded item is pending
  `BETS_ASSERT_SAME(a_stall, !in_ready, enc_valid && !stat.take)

endmodule

FILE: sim/big_endian_typed_serializer_tb.sv
// Self-checking testbench for big_endian_typed_serializer: typed values in, bytes out.
// Depends on bets_pkg for the operation codes and on the RTL of the block.
// It predicts every byte, its last flag and the running count, and checks each byte in order.
module big_endian_typed_serializer_tb;
  import bets_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Operation codes that the block accepts and drops
  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;

  localparam int RANDOM_ITEMS = 208;
  localparam int QUIET_TAIL   = 30;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [2:0]  op;
    logic [63:0] value;
    bit          drain;
  } typed_item_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [31:0] count;
  } serial_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_operation = OP_BYTE;
  logic [63:0] in_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_byte;
  logic [31:0] out_bytes_written;

  typed_item_t  item_q[$];
  serial_byte_t stream_q[$];
  logic [31:0]  byte_tally = '0;
  bit           in_fire = 1'b0;
  int           send_gap = 0;
  int           hold_gap = 0;
  int           stalled = 0;
  int           fail_count = 0;
  int           bytes_checked = 0;
  int           op_seen[8];

  big_endian_typed_serializer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .out_bytes_written(out_bytes_written)
  );

  always #1 clk = ~clk;

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    fail_count++;
    $display("ERROR %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endtask

  // Serialize one transaction into the expected byte stream, MSB first
  task automatic serialize_item(input logic [2:0] op, input logic [63:0] v);
    logic [15:0]  unit;
    logic [63:0]  word;
    int           n;
    serial_byte_t b;
    unit = v[15:0];
    word = v;
    n = 0;
    case (op)
      OP_BYTE:  n = 1;
      OP_BOOL: begin
        word = (v != '0) ? 64'd1 : 64'd0;
        n = 1;
      end
      OP_SHORT: n = 2;
      OP_INT:   n = 4;
      OP_LONG:  n = 8;
      OP_UTF: begin
        if (unit >= 16'h0001 && unit <= 16'h007F) begin
          word = {48'b0, unit};
          n = 1;
        end else if (unit > 16'h07FF) begin
          word = {40'b0, 4'hE, unit[15:12], 2'b10, unit[11:6], 2'b10, unit[5:0]};
          n = 3;
        end else begin
          // zero and two-byte range share the two-byte form
          word = {48'b0, 3'b110, unit[10:6], 2'b10, unit[5:0]};
          n = 2;
        end
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++) begin
      byte_tally = byte_tally + 32'd1;
      b.data  = word[8 * (n - 1 - k) +: 8];
      b.last  = (k == n - 1);
      b.count = byte_tally;
      stream_q.push_back(b);
    end
  endtask

  function automatic typed_item_t random_item();
    typed_item_t it;
    int          pick;
    pick = $urandom_range(0, 15);
    it.drain = 1'b0;
    it.value = {$urandom, $urandom};
    if (pick >= 14) begin
      it.op = (pick == 14) ? OP_SPARE_A : OP_SPARE_B;
      return it;
    end
    case (pick % 6)
      0: it.op = OP_BYTE;
      1: it.op = OP_BOOL;
      2: it.op = OP_SHORT;
      3: it.op = OP_INT;
      4: it.op = OP_LONG;
      default: it.op = OP_UTF;
    endcase
    if (it.op == OP_BOOL) begin
      case ($urandom_range(0, 2))
        0: it.value = '0;
        1: it.value = 64'd1 << $urandom_range(0, 63);
        default: ;
      endcase
    end else if (it.op == OP_UTF) begin
      // spread code units over the three encoding lengths and zero
      case ($urandom_range(0, 3))
        0: it.value[15:0] = 16'h0000;
        1: it.value[15:0] = 16'($urandom_range(16'h0001, 16'h007F));
        2: it.value[15:0] = 16'($urandom_range(16'h0080, 16'h07FF));
        default: it.value[15:0] = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
    end
    return it;
  endfunction

  function automatic typed_item_t make_item(input logic [2:0] op, input logic [63:0] v);
    typed_item_t it;
    it.op = op;
    it.value = v;
    it.drain = 1'b0;
    return it;
  endfunction

  // Drive the input channel: hold until accepted, insert random gaps, honor drains
  always @(negedge clk) begin : drive_in
    typed_item_t nxt;
    bit          quiet;
    quiet = (item_q.size() < QUIET_TAIL) || (item_q.size() > 110 && item_q.size() < 140);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (item_q.size() == 0) begin
      in_valid <= 1'b0;
    end else if (item_q[0].drain && stream_q.size() != 0) begin
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(1, 14) - 1;
      in_valid <= 1'b0;
    end else begin
      nxt = item_q.pop_front();
      in_valid     <= 1'b1;
      in_operation <= nxt.op;
      in_value     <= nxt.value;
    end
  end

  // Drive backpressure on the output channel in random bursts
  always @(negedge clk) begin : drive_out
    bit quiet;
    quiet = (item_q.size() < QUIET_TAIL) || (item_q.size() > 110 && item_q.size() < 140);
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_gap > 0) begin
      hold_gap--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      hold_gap = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on each input transaction, check each output transaction
  always @(posedge clk) begin : watch
    serial_byte_t want;
    bit           out_fire;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (in_fire) begin
      op_seen[in_operation]++;
      serialize_item(in_operation, in_value);
    end
    if (out_fire) begin
      bytes_checked++;
      if (stream_q.size() == 0) begin
        report_mismatch("unexpected byte", '0, {24'b0, out_bytes_written, out_byte});
      end else begin
        want = stream_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", {56'b0, want.data}, {56'b0, out_byte});
        if (out_last_byte !== want.last)
          report_mismatch("out_last_byte", {63'b0, want.last}, {63'b0, out_last_byte});
        if (out_bytes_written !== want.count)
          report_mismatch("out_bytes_written", {32'b0, want.count},
                          {32'b0, out_bytes_written});
      end
    end
    stalled = (in_fire || out_fire || !rst_n) ? 0 : stalled + 1;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (stalled >= STALL_LIMIT) begin
      $display("ERROR %0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("big_endian_typed_serializer: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    typed_item_t it;
    int          taken;
    // Directed: field extremes, every kind, UTF length boundaries, dropped codes
    item_q.push_back(make_item(OP_BYTE,  64'h0));
    item_q.push_back(make_item(OP_BYTE,  64'hFF));
    item_q.push_back(make_item(OP_BYTE,  64'hFFFF_FFFF_FFFF_FF5A));
    item_q.push_back(make_item(OP_BOOL,  64'h0));
    item_q.push_back(make_item(OP_BOOL,  64'h8000_0000_0000_0000));
    item_q.push_back(make_item(OP_BOOL,  64'hFFFF_FFFF_FFFF_FFFF));
    item_q.push_back(make_item(OP_SHORT, 64'h0));
    item_q.push_back(make_item(OP_SHORT, 64'hDEAD_BEEF_0000_A55A));
    item_q.push_back(make_item(OP_INT,   64'hFFFF_FFFF));
    item_q.push_back(make_item(OP_INT,   64'h1234_5678_89AB_CDEF));
    item_q.push_back(make_item(OP_LONG,  64'h0));
    item_q.push_back(make_item(OP_LONG,  64'hFFFF_FFFF_FFFF_FFFF));
    item_q.push_back(make_item(OP_LONG,  64'h0123_4567_89AB_CDEF));
    item_q.push_back(make_item(OP_UTF,   64'h0));
    item_q.push_back(make_item(OP_UTF,   64'h1));
    item_q.push_back(make_item(OP_UTF,   64'h7F));
    item_q.push_back(make_item(OP_UTF,   64'h80));
    item_q.push_back(make_item(OP_UTF,   64'h7FF));
    item_q.push_back(make_item(OP_UTF,   64'h800));
    item_q.push_back(make_item(OP_UTF,   64'hFFFF_FFFF_FFFF_FFFF));
    item_q.push_back(make_item(OP_SPARE_A, 64'hFFFF_FFFF_FFFF_FFFF));
    item_q.push_back(make_item(OP_SPARE_B, 64'h0));

    // Random part; a few items wait for the output to drain first
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      it = random_item();
      if (taken == 0 || taken == 100 || taken == 180)
        it.drain = 1'b1;
      taken++;
      item_q.push_back(it);
    end

    // Release reset at a falling edge, then wait for everything to go through
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    while (item_q.size() != 0 || in_valid || stream_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bytes, bools %0d, shorts %0d, ints %0d, longs %0d, UTF units %0d,",
             op_seen[OP_BYTE], op_seen[OP_BOOL], op_seen[OP_SHORT], op_seen[OP_INT],
             op_seen[OP_LONG], op_seen[OP_UTF]);
    $display("dropped codes %0d; %0d output bytes checked, %0d errors",
             op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B], bytes_checked, fail_count);
    if (fail_count == 0)
      $display("big_endian_typed_serializer: match");
    else
      $display("big_endian_typed_serializer: mismatch");
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/bets_pkg.sv
hdl/bets_encoder.sv
hdl/bets_serializer.sv
hdl/big_endian_typed_serializer.sv
sim/big_endian_typed_serializer_tb.sv
